/* sv/adri_pkg.sv */
// Shared types and constants for the accelerometer dead-reckoning integrator.
// Used by adri_rootdiv, adri_cordic and the top level; no dependencies.
`default_nettype none

package adri_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CD_W         = 20;
    localparam int CD_IT_W      = $clog2(ATAN_LEN);

    localparam int SQRT_STEPS   = 16;
    localparam int DIV_STEPS    = 30;
    localparam int RD_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [15:0] ATAN_Q16 [ATAN_LEN] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047,
        16'd1024, 16'd512, 16'd256, 16'd128, 16'd64, 16'd32,
        16'd16, 16'd8, 16'd4, 16'd2, 16'd1, 16'd0,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd4;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } t_rd_op;

    typedef struct packed {
        logic        start;
        t_rd_op      op;
        logic [31:0] a;     // radicand, or dividend in [29:0]
        logic [15:0] d;     // divisor
    } t_rd_cmd;

    typedef struct packed {
        logic                   start;
        logic                   vec;   // 1: vectoring, 0: rotation
        logic signed [CD_W-1:0] x;
        logic signed [CD_W-1:0] y;
        logic signed [CD_W-1:0] z;
    } t_cd_cmd;

endpackage

`default_nettype wire

/* sv/adri_rootdiv.sv */
// Iterative integer square root (2 bits a step) and unsigned divider (1 bit a step).
// Depends on adri_pkg.
`default_nettype none

module adri_rootdiv (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  adri_pkg::t_rd_cmd    i_cmd,
    output logic                 o_done,
    output logic [29:0]          o_res
);

    logic                               r_busy;
    logic [adri_pkg::RD_CNT_W-1:0]      r_cnt;
    adri_pkg::t_rd_op                   r_op;
    logic [31:0]                        r_src;
    logic [18:0]                        r_rem;
    logic [29:0]                        r_res;
    logic [15:0]                        r_d;
    logic                               r_done;

    logic [18:0] sq_rem2, sq_trial;
    logic [16:0] dv_rem2;

    assign sq_rem2  = {r_rem[16:0], r_src[31:30]};
    assign sq_trial = {1'b0, r_res[15:0], 2'b01};
    assign dv_rem2  = {r_rem[15:0], r_src[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= adri_pkg::RD_SQRT;
            r_src  <= '0;
            r_rem  <= '0;
            r_res  <= '0;
            r_d    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_d    <= i_cmd.d;
                r_rem  <= '0;
                r_res  <= '0;
                if (i_cmd.op == adri_pkg::RD_SQRT) begin
                    r_src <= i_cmd.a;
                    r_cnt <= adri_pkg::RD_CNT_W'(adri_pkg::SQRT_STEPS - 1);
                end else begin
                    r_src <= {i_cmd.a[29:0], 2'b00};
                    r_cnt <= adri_pkg::RD_CNT_W'(adri_pkg::DIV_STEPS - 1);
                end
            end else if (r_busy) begin
                if (r_op == adri_pkg::RD_SQRT) begin
                    r_src <= {r_src[29:0], 2'b00};
                    if (sq_rem2 >= sq_trial) begin
                        r_rem <= sq_rem2 - sq_trial;
                        r_res <= {r_res[28:0], 1'b1};
                    end else begin
                        r_rem <= sq_rem2;
                        r_res <= {r_res[28:0], 1'b0};
                    end
                end else begin
                    r_src <= {r_src[30:0], 1'b0};
                    if (dv_rem2 >= {1'b0, r_d}) begin
                        r_rem <= 19'(dv_rem2 - {1'b0, r_d});
                        r_res <= {r_res[28:0], 1'b1};
                    end else begin
                        r_rem <= 19'(dv_rem2);
                        r_res <= {r_res[28:0], 1'b0};
                    end
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

/* sv/adri_cordic.sv */
// Iterative CORDIC, one micro-rotation a cycle, vectoring or rotation mode.
// Depends on adri_pkg (arctangent table, widths).
`default_nettype none

module adri_cordic (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  adri_pkg::t_cd_cmd                   i_cmd,
    output logic                                o_done,
    output logic signed [adri_pkg::CD_W-1:0]    o_x,
    output logic signed [adri_pkg::CD_W-1:0]    o_y,
    output logic signed [adri_pkg::CD_W-1:0]    o_z
);

    localparam int W = adri_pkg::CD_W;

    logic                               r_busy;
    logic                               r_done;
    logic                               r_vec;
    logic [adri_pkg::CD_IT_W-1:0]       r_it;
    logic signed [W-1:0]                r_x, r_y, r_z;

    logic signed [W-1:0] dx, dy, at;
    logic                plus;

    assign dx   = r_y >>> r_it;
    assign dy   = r_x >>> r_it;
    assign at   = W'(adri_pkg::ATAN_Q16[r_it]);
    // vectoring drives y to zero, rotation drives z to zero
    assign plus = r_vec ? (r_y >= 0) : (r_z < 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_vec  <= 1'b0;
            r_it   <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_vec  <= i_cmd.vec;
                r_it   <= '0;
                r_x    <= i_cmd.x;
                r_y    <= i_cmd.y;
                r_z    <= i_cmd.z;
            end else if (r_busy) begin
                if (plus) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end
                if (r_it == adri_pkg::CD_IT_W'(adri_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_it <= r_it + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

`default_nettype wire

/* sv/accel_dead_reckoning_integrator_top.sv */
// Top level: sequencer, shared multiplier, accumulators and stream ports.
// Depends on adri_pkg, adri_rootdiv and adri_cordic.
`default_nettype none

// One sample is taken per input beat and gives one result beat. The block
// works on one sample at a time. The time per sample is set by the iterative
// square root (16 steps), divider (30 steps) and CORDIC (16 steps); it is
// longer with a tilt update, and with a vertical pitch the roll division is
// skipped. These units are shared across all steps of the sequence. A
// finished result waits in the output register, so the next sample is taken
// while it is pending. Only the result stage waits on a stalled output.
// Registers are written through the cfg port, which is always ready; write
// them only while no sample is in progress.
module accel_dead_reckoning_integrator_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], heading_deg[56:48]
    input  wire  [63:0]                         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // pitch_angle[13:0], roll_angle[28:14], velocity_out[60:29],
    // distance_out[92:61], disp_north[124:93], disp_east[156:125]
    output logic [159:0]                        m_axis_tdata,
    // tilt_updated[0], stillness_reset[1]
    output logic [1:0]                          m_axis_tuser,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [adri_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [15:0]                         i_cfg_data
);

    localparam logic [20:0] G_Q16      = 21'd642253;
    localparam logic [19:0] K_Q16      = 20'd39797;
    localparam logic [24:0] DEG_Q24    = 25'd292818;
    localparam logic [15:0] IDLE_LEVEL = 16'd82;

    typedef enum logic [4:0] {
        S_IDLE, S_MX, S_MY, S_MZ, S_MSUM, S_ROOT, S_DIVX, S_DIVY, S_CX,
        S_PITCH, S_DIVQ, S_SQQ, S_CQS, S_CQ, S_ROLL, S_CHG, S_DV, S_VEL,
        S_DSM, S_DS, S_HROT, S_NMUL, S_NORTH, S_EAST, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [14:0] r_baseline, r_tilt;
    logic [13:0] r_noise;
    logic [7:0]  r_still_lim;
    logic [15:0] r_step;

    // sample and working registers
    logic signed [15:0] r_ax, r_ay, r_az, r_sx, r_sy, r_q;
    logic [8:0]         r_h;
    logic [31:0]        r_sum;
    logic signed [53:0] r_prod;
    logic [15:0]        r_mag, r_change;
    logic [14:0]        r_c;
    logic               r_upd, r_still;
    logic signed [31:0] r_ds;
    logic signed [17:0] r_co, r_si;
    logic [1:0]         r_quad;

    // state carried between samples
    logic signed [31:0] r_speed, r_path, r_north, r_east;
    logic [7:0]         r_idle;
    logic signed [13:0] r_pitch;
    logic [14:0]        r_roll;

    logic               r_m_valid;
    logic [159:0]       r_m_data;
    logic [1:0]         r_m_user;

    adri_pkg::t_rd_cmd  r_rd_cmd;
    adri_pkg::t_cd_cmd  r_cd_cmd;
    logic               rd_done, cd_done;
    logic [29:0]        rd_res;
    logic signed [adri_pkg::CD_W-1:0] cd_x, cd_y, cd_z;

    adri_rootdiv u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_rd_cmd),
        .o_done  (rd_done),
        .o_res   (rd_res)
    );

    adri_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cd_cmd),
        .o_done  (cd_done),
        .o_x     (cd_x),
        .o_y     (cd_y),
        .o_z     (cd_z)
    );

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] to_q12(input logic signed [19:0] z);
        logic signed [19:0] t;
        t = z + 20'sd8;
        return t[19:4];
    endfunction

    function automatic logic signed [17:0] clamp_unit(input logic signed [19:0] v);
        if (v > 20'sd65536) begin
            return 18'sd65536;
        end else if (v < -20'sd65536) begin
            return -18'sd65536;
        end
        return v[17:0];
    endfunction

    // shared multiplier, operands chosen by the sequencer
    logic signed [32:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [53:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MX:    begin mul_a = 33'(r_ax); mul_b = 21'(r_ax); end
            S_MY:    begin mul_a = 33'(r_ay); mul_b = 21'(r_ay); end
            S_MZ:    begin mul_a = 33'(r_az); mul_b = 21'(r_az); end
            S_DIVY:  begin mul_a = 33'(r_sx); mul_b = 21'(r_sx); end
            S_SQQ:   begin mul_a = 33'(r_q);  mul_b = 21'(r_q);  end
            S_CHG:   begin mul_a = {17'b0, r_change}; mul_b = {5'b0, r_step}; end
            S_DV:    begin mul_a = {1'b0, r_prod[31:0]}; mul_b = G_Q16; end
            S_DSM:   begin mul_a = 33'(r_speed); mul_b = {5'b0, r_step}; end
            S_NMUL:  begin mul_a = 33'(r_ds); mul_b = 21'(r_co); end
            S_NORTH: begin mul_a = 33'(r_ds); mul_b = 21'(r_si); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = 54'(mul_a) * 54'(mul_b);

    // heading split into quadrant and remainder angle
    logic [8:0]         h_mod;
    logic [6:0]         h_rem;
    logic [1:0]         h_quad;
    logic [24:0]        h_prod;
    logic signed [19:0] h_z;

    always_comb begin
        h_mod = (r_h >= 9'd360) ? 9'(r_h - 9'd360) : r_h;
        if (h_mod >= 9'd270) begin
            h_quad = 2'd3; h_rem = 7'(h_mod - 9'd270);
        end else if (h_mod >= 9'd180) begin
            h_quad = 2'd2; h_rem = 7'(h_mod - 9'd180);
        end else if (h_mod >= 9'd90) begin
            h_quad = 2'd1; h_rem = 7'(h_mod - 9'd90);
        end else begin
            h_quad = 2'd0; h_rem = 7'(h_mod);
        end
        h_prod = {18'b0, h_rem} * DEG_Q24 + 25'd128;
        h_z    = 20'({3'b0, h_prod[24:8]});
    end

    // working values taken from unit results
    logic [15:0]        abs_x, abs_y, abs_sy, rd_mag;
    logic signed [16:0] chg_raw;
    logic signed [15:0] pq12, rq12;
    logic signed [16:0] roll_full;
    logic [15:0]        q_mag;
    logic [8:0]         idle_inc;
    logic signed [33:0] spd_sum, path_sum, north_sum, east_sum;
    logic signed [53:0] rnd_prod;
    logic [53:0]        dv_sum;
    logic signed [17:0] hx, hy;

    always_comb begin
        abs_x     = r_ax[15] ? 16'(-r_ax) : 16'(r_ax);
        abs_y     = r_ay[15] ? 16'(-r_ay) : 16'(r_ay);
        abs_sy    = r_sy[15] ? 16'(-r_sy) : 16'(r_sy);
        rd_mag    = rd_res[15:0];
        chg_raw   = $signed({1'b0, rd_mag}) - $signed({2'b0, r_baseline});
        pq12      = to_q12(cd_z);
        rq12      = to_q12(cd_z);
        roll_full = 17'sd25736 - 17'(rq12);
        q_mag     = (rd_res > 30'd16384) ? 16'd16384 : rd_res[15:0];
        idle_inc  = {1'b0, r_idle} + 9'd1;
        dv_sum    = r_prod + 54'sd536870912;
        spd_sum   = 34'(r_speed) + $signed({10'b0, dv_sum[53:30]});
        rnd_prod  = r_prod + 54'sd32768;
        path_sum  = 34'(r_path) + 34'($signed(rnd_prod[47:16]));
        north_sum = 34'(r_north) + 34'($signed(rnd_prod[47:16]));
        east_sum  = 34'(r_east) + 34'($signed(rnd_prod[47:16]));
        hx        = clamp_unit(cd_x);
        hy        = clamp_unit(cd_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_baseline  <= 15'd16384;
            r_tilt      <= 15'd18022;
            r_noise     <= 14'd328;
            r_still_lim <= 8'd50;
            r_step      <= 16'd1638;
            r_speed     <= '0;
            r_path      <= '0;
            r_north     <= '0;
            r_east      <= '0;
            r_idle      <= '0;
            r_pitch     <= '0;
            r_roll      <= '0;
            r_m_valid   <= 1'b0;
            r_m_data    <= '0;
            r_m_user    <= '0;
            r_rd_cmd    <= '0;
            r_cd_cmd    <= '0;
            r_ax <= '0; r_ay <= '0; r_az <= '0; r_h <= '0;
            r_sx <= '0; r_sy <= '0; r_q <= '0; r_sum <= '0; r_prod <= '0;
            r_mag <= '0; r_change <= '0; r_c <= '0; r_upd <= 1'b0;
            r_still <= 1'b0; r_ds <= '0; r_co <= '0; r_si <= '0; r_quad <= '0;
        end else begin
            r_rd_cmd.start <= 1'b0;
            r_cd_cmd.start <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    adri_pkg::CFG_BASELINE: r_baseline  <= i_cfg_data[14:0];
                    adri_pkg::CFG_TILT:     r_tilt      <= i_cfg_data[14:0];
                    adri_pkg::CFG_NOISE:    r_noise     <= i_cfg_data[13:0];
                    adri_pkg::CFG_STILL:    r_still_lim <= i_cfg_data[7:0];
                    adri_pkg::CFG_STEP:     r_step      <= i_cfg_data;
                    default: ;
                endcase
            end

            // in S_DONE the result stage itself decides the valid flag
            if (r_m_valid && m_axis_tready && r_state != S_DONE) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_ax    <= s_axis_tdata[15:0];
                        r_ay    <= s_axis_tdata[31:16];
                        r_az    <= s_axis_tdata[47:32];
                        r_h     <= s_axis_tdata[56:48];
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    r_prod  <= mul_p;
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_sum   <= r_prod[31:0];
                    r_prod  <= mul_p;
                    r_state <= S_MZ;
                end
                S_MZ: begin
                    r_sum   <= r_sum + r_prod[31:0];
                    r_prod  <= mul_p;
                    r_state <= S_MSUM;
                end
                S_MSUM: begin
                    r_rd_cmd <= '{start: 1'b1, op: adri_pkg::RD_SQRT,
                                  a: r_sum + r_prod[31:0], d: 16'd0};
                    r_state  <= S_ROOT;
                end
                S_ROOT: begin
                    if (rd_done) begin
                        r_mag    <= rd_mag;
                        r_change <= (chg_raw < $signed({3'b0, r_noise})) ? 16'd0
                                                                         : chg_raw[15:0];
                        if (rd_mag < {1'b0, r_tilt} && rd_mag != 16'd0) begin
                            r_upd    <= 1'b1;
                            r_rd_cmd <= '{start: 1'b1, op: adri_pkg::RD_DIV,
                                          a: {2'b0, abs_x, 14'b0}, d: rd_mag};
                            r_state  <= S_DIVX;
                        end else begin
                            r_upd   <= 1'b0;
                            r_state <= S_CHG;
                        end
                    end
                end
                S_DIVX: begin
                    if (rd_done) begin
                        r_sx     <= r_ax[15] ? 16'(-rd_res[15:0]) : rd_res[15:0];
                        r_rd_cmd <= '{start: 1'b1, op: adri_pkg::RD_DIV,
                                      a: {2'b0, abs_y, 14'b0}, d: r_mag};
                        r_state  <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    // sx squared is formed while the divider runs
                    r_prod <= mul_p;
                    if (rd_done) begin
                        r_sy     <= r_ay[15] ? 16'(-rd_res[15:0]) : rd_res[15:0];
                        r_rd_cmd <= '{start: 1'b1, op: adri_pkg::RD_SQRT,
                                      a: {3'b0, 29'(29'h1000_0000 - r_prod[28:0])},
                                      d: 16'd0};
                        r_state  <= S_CX;
                    end
                end
                S_CX: begin
                    if (rd_done) begin
                        r_c      <= rd_res[14:0];
                        r_cd_cmd <= '{start: 1'b1, vec: 1'b1,
                                      x: 20'({5'b0, rd_res[14:0]}),
                                      y: 20'(r_sx), z: 20'sd0};
                        r_state  <= S_PITCH;
                    end
                end
                S_PITCH: begin
                    if (cd_done) begin
                        if (pq12 > 16'sd6434) begin
                            r_pitch <= 14'sd6434;
                        end else if (pq12 < -16'sd6434) begin
                            r_pitch <= -14'sd6434;
                        end else begin
                            r_pitch <= pq12[13:0];
                        end
                        if (r_c != 15'd0) begin
                            r_rd_cmd <= '{start: 1'b1, op: adri_pkg::RD_DIV,
                                          a: {2'b0, abs_sy, 14'b0}, d: {1'b0, r_c}};
                            r_state  <= S_DIVQ;
                        end else begin
                            // pitch at ninety degrees: roll argument is zero
                            r_q     <= '0;
                            r_state <= S_SQQ;
                        end
                    end
                end
                S_DIVQ: begin
                    if (rd_done) begin
                        r_q     <= r_sy[15] ? 16'(-q_mag) : q_mag;
                        r_state <= S_SQQ;
                    end
                end
                S_SQQ: begin
                    r_prod  <= mul_p;
                    r_state <= S_CQS;
                end
                S_CQS: begin
                    r_rd_cmd <= '{start: 1'b1, op: adri_pkg::RD_SQRT,
                                  a: {3'b0, 29'(29'h1000_0000 - r_prod[28:0])},
                                  d: 16'd0};
                    r_state  <= S_CQ;
                end
                S_CQ: begin
                    if (rd_done) begin
                        r_cd_cmd <= '{start: 1'b1, vec: 1'b1,
                                      x: 20'({4'b0, rd_res[15:0]}),
                                      y: 20'(r_q), z: 20'sd0};
                        r_state  <= S_ROLL;
                    end
                end
                S_ROLL: begin
                    if (cd_done) begin
                        r_roll  <= roll_full[14:0];
                        r_state <= S_CHG;
                    end
                end
                S_CHG: begin
                    r_prod  <= mul_p;
                    r_still <= 1'b0;
                    if (r_change < IDLE_LEVEL) begin
                        if (8'(r_idle == 8'd255 ? r_idle : idle_inc[7:0]) > r_still_lim) begin
                            r_still <= 1'b1;
                            r_idle  <= '0;
                        end else if (r_idle != 8'd255) begin
                            r_idle  <= idle_inc[7:0];
                        end
                    end
                    r_state <= S_DV;
                end
                S_DV: begin
                    r_prod  <= mul_p;
                    r_state <= S_VEL;
                end
                S_VEL: begin
                    r_speed <= r_still ? 32'sd0 : sat32(spd_sum);
                    r_state <= S_DSM;
                end
                S_DSM: begin
                    r_prod  <= mul_p;
                    r_state <= S_DS;
                end
                S_DS: begin
                    r_ds     <= rnd_prod[47:16];
                    r_path   <= sat32(path_sum);
                    r_quad   <= h_quad;
                    r_cd_cmd <= '{start: 1'b1, vec: 1'b0,
                                  x: K_Q16, y: 20'sd0, z: h_z};
                    r_state  <= S_HROT;
                end
                S_HROT: begin
                    if (cd_done) begin
                        case (r_quad)
                            2'd0:    begin r_co <= hx;  r_si <= hy;  end
                            2'd1:    begin r_co <= -hy; r_si <= hx;  end
                            2'd2:    begin r_co <= -hx; r_si <= -hy; end
                            default: begin r_co <= hy;  r_si <= -hx; end
                        endcase
                        r_state <= S_NMUL;
                    end
                end
                S_NMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_NORTH;
                end
                S_NORTH: begin
                    r_north <= sat32(north_sum);
                    r_prod  <= mul_p;
                    r_state <= S_EAST;
                end
                S_EAST: begin
                    r_east  <= sat32(east_sum);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {3'b0, r_east, r_north, r_path, r_speed,
                                      r_roll, r_pitch};
                        r_m_user  <= {r_still, r_upd};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign o_cfg_ready   = 1'b1;

    // a stillness expiry always delivers zero velocity
    a_still_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[60:29] == 32'd0)
        else $error("velocity not zero on stillness reset");

    // unit completions only arrive while the sequencer waits for them
    a_cd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cd_done |-> (r_state == S_PITCH || r_state == S_ROLL || r_state == S_HROT))
        else $error("cordic done outside a wait state");

    a_rd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_done |-> (r_state == S_ROOT || r_state == S_DIVX || r_state == S_DIVY ||
                     r_state == S_CX || r_state == S_DIVQ || r_state == S_CQ))
        else $error("root/div done outside a wait state");

    // held pitch stays within a quarter turn
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pitch <= 14'sd6434 && r_pitch >= -14'sd6434)
        else $error("pitch hold out of range");

endmodule

`default_nettype wire
